FILE: rtl/ucal_pkg.sv
package ucal_pkg;

	localparam logic [11:0] YEAR_BASE  = 12'd1970;
	localparam logic [11:0] YEAR_NOLEAP = 12'd2100;
	localparam logic [8:0]  YLEN_LEAP  = 9'd366;
	localparam logic [8:0]  YLEN_NORM  = 9'd365;
	localparam logic [3:0]  MON_DEC    = 4'd11;
	localparam logic [3:0]  MON_FEB    = 4'd1;

	// reciprocal constants: q = (n * RECIP) >> SHIFT, exact for 32-bit n
	localparam logic [31:0] RECIP_60   = 32'h8888_8889;
	localparam logic [31:0] RECIP_24   = 32'hAAAA_AAAB;
	localparam logic [5:0]  DIVISOR_60 = 6'd60;
	localparam logic [5:0]  DIVISOR_24 = 6'd24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_REM,
		ST_YEAR,
		ST_MONTH,
		ST_PUSH
	} state_t;

	typedef enum logic [1:0] {
		DIV_SEC,
		DIV_MIN,
		DIV_HOUR
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul;
		logic     divr;
		div_sel_t dsel;
		logic     year_step;
		logic     month_step;
		logic     push;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
		logic out_busy;
	} status_t;

	function automatic logic leap_year(input logic [11:0] y);
		leap_year = (y[1:0] == 2'd0) && (y != YEAR_NOLEAP);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			4'd0: month_len = 5'd31;
			MON_FEB: month_len = leap ? 5'd29 : 5'd28;
			4'd2: month_len = 5'd31;
			4'd3: month_len = 5'd30;
			4'd4: month_len = 5'd31;
			4'd5: month_len = 5'd30;
			4'd6: month_len = 5'd31;
			4'd7: month_len = 5'd31;
			4'd8: month_len = 5'd30;
			4'd9: month_len = 5'd31;
			4'd10: month_len = 5'd30;
			4'd11: month_len = 5'd31;
			default: month_len = 5'd31;
		endcase
	endfunction

endpackage

FILE: rtl/ucal_ctrl.sv
module ucal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ts_valid,
	output logic              ts_stall,
	input  ucal_pkg::status_t sts,
	output ucal_pkg::cmd_t    cmd
);
	import ucal_pkg::*;

	state_t   state_q, state_d;
	div_sel_t dsel_q, dsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dsel_q  <= DIV_SEC;
		end else begin
			state_q <= state_d;
			dsel_q  <= dsel_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		dsel_d   = dsel_q;
		cmd      = '0;
		cmd.dsel = dsel_q;
		ts_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				ts_stall = 1'b0;
				if (ts_valid) begin
					cmd.load = 1'b1;
					dsel_d   = DIV_SEC;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.divr = 1'b1;
				case (dsel_q)
					DIV_SEC: begin
						dsel_d  = DIV_MIN;
						state_d = ST_MUL;
					end
					DIV_MIN: begin
						dsel_d  = DIV_HOUR;
						state_d = ST_MUL;
					end
					default: state_d = ST_YEAR;
				endcase
			end
			ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (sts.year_done) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (!sts.out_busy) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/ucal_dp.sv
module ucal_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ucal_pkg::cmd_t    cmd,
	output ucal_pkg::status_t sts,
	input  logic [31:0]       unix_seconds,
	input  logic              cal_stall,
	output logic              cal_valid,
	output logic [11:0]       year_out,
	output logic [3:0]        month_out,
	output logic [4:0]        day_out,
	output logic [4:0]        hour_out,
	output logic [5:0]        minute_out,
	output logic [5:0]        second_out
);
	import ucal_pkg::*;

	logic [31:0] opnd_q;
	logic [63:0] prod_q;
	logic [5:0]  sec_q, min_q;
	logic [4:0]  hour_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic        valid_q;

	logic [11:0] year_oq;
	logic [3:0]  mon_oq;
	logic [4:0]  day_oq;
	logic [4:0]  hour_oq;
	logic [5:0]  min_oq, sec_oq;

	logic [31:0] recip;
	logic [5:0]  divisor;
	logic [31:0] quot;
	logic [31:0] rem;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	always_comb begin
		case (cmd.dsel)
			DIV_HOUR: begin
				recip   = RECIP_24;
				divisor = DIVISOR_24;
				quot    = {4'd0, prod_q[63:36]};
			end
			default: begin
				recip   = RECIP_60;
				divisor = DIVISOR_60;
				quot    = {5'd0, prod_q[63:37]};
			end
		endcase
		rem  = opnd_q - quot * {26'd0, divisor};
		leap = leap_year(year_q);
		ylen = leap ? YLEN_LEAP : YLEN_NORM;
		mlen = month_len(mon_q, leap);
	end

	assign sts.year_done  = days_q < {7'd0, ylen};
	assign sts.month_done = (mon_q == MON_DEC) || (days_q < {11'd0, mlen});
	assign sts.out_busy   = valid_q && cal_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) opnd_q <= unix_seconds;
		if (cmd.mul)  prod_q <= {32'd0, opnd_q} * {32'd0, recip};
		if (cmd.divr) begin
			opnd_q <= quot;
			case (cmd.dsel)
				DIV_SEC: sec_q <= rem[5:0];
				DIV_MIN: min_q <= rem[5:0];
				default: begin
					hour_q <= rem[4:0];
					days_q <= quot[15:0];
					year_q <= YEAR_BASE;
					mon_q  <= 4'd0;
				end
			endcase
		end
		if (cmd.year_step && !sts.year_done) begin
			days_q <= days_q - {7'd0, ylen};
			year_q <= year_q + 12'd1;
		end
		if (cmd.month_step && !sts.month_done) begin
			days_q <= days_q - {11'd0, mlen};
			mon_q  <= mon_q + 4'd1;
		end
		if (cmd.push) begin
			year_oq <= year_q;
			mon_oq  <= mon_q + 4'd1;
			day_oq  <= days_q[4:0] + 5'd1;
			hour_oq <= hour_q;
			min_oq  <= min_q;
			sec_oq  <= sec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			valid_q <= 1'b1;
		end else if (!cal_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign cal_valid  = valid_q;
	assign year_out   = year_oq;
	assign month_out  = mon_oq;
	assign day_out    = day_oq;
	assign hour_out   = hour_oq;
	assign minute_out = min_oq;
	assign second_out = sec_oq;

endmodule

FILE: rtl/unix_seconds_to_calendar_core.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into UTC year, month,
// day, hour, minute and second, one transaction at a time. Second, minute and hour come
// from three reciprocal multiplications on one shared 32x32 multiplier;
// the remaining days are then used up one year per cycle from 1970 and one month per
// cycle. A finished result waits for as long as the previous one is stalled in the
// output register, and the next timestamp is accepted in the cycle after the result
// is loaded into the output register. The result register holds while the consumer
// stalls.
module unix_seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ts_valid,
	output logic        ts_stall,
	input  logic [31:0] unix_seconds,
	output logic        cal_valid,
	input  logic        cal_stall,
	output logic [11:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out
);
	import ucal_pkg::*;

	cmd_t    cmd;
	status_t sts;

	ucal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ts_valid (ts_valid),
		.ts_stall (ts_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ucal_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.unix_seconds (unix_seconds),
		.cal_stall    (cal_stall),
		.cal_valid    (cal_valid),
		.year_out     (year_out),
		.month_out    (month_out),
		.day_out      (day_out),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.second_out   (second_out)
	);

endmodule

FILE: rtl/ucal_checker.sv
module ucal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        ts_valid,
	input logic        ts_stall,
	input logic [31:0] unix_seconds,
	input logic        cal_valid,
	input logic        cal_stall,
	input logic [11:0] year_out,
	input logic [3:0]  month_out,
	input logic [4:0]  day_out,
	input logic [4:0]  hour_out,
	input logic [5:0]  minute_out,
	input logic [5:0]  second_out
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid && cal_stall |=> cal_valid && $stable(year_out) && $stable(month_out)
			&& $stable(day_out) && $stable(hour_out) && $stable(minute_out)
			&& $stable(second_out))
		else $error("stalled result changed");

	// stalled input transaction holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && ts_stall |=> ts_valid && $stable(unix_seconds))
		else $error("stalled input changed");

	// one transaction in flight: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && !ts_stall |=> ts_stall)
		else $error("input accepted while busy");

	// fields within calendar ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1)
			&& (hour_out < 5'd24) && (minute_out < 6'd60) && (second_out < 6'd60)
			&& (year_out >= 12'd1970) && (year_out <= 12'd2106))
		else $error("result field out of range");

endmodule

bind unix_seconds_to_calendar_core ucal_checker u_chk (.*);

FILE: tb/unix_seconds_to_calendar_core_test.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
} calendar_t;

class calendar_board;
	calendar_t   expected_q[$];
	int unsigned mismatches;
	int unsigned checked;
	int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	function bit is_leap(int unsigned yr);
		return (yr % 4 == 0) && (yr != 32'(ucal_pkg::YEAR_NOLEAP));
	endfunction

	function calendar_t convert(logic [31:0] stamp);
		calendar_t   c;
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		t = stamp;
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		days = t / 24;
		yr = 32'(ucal_pkg::YEAR_BASE);
		while (days >= (is_leap(yr) ? 366 : 365)) begin
			days -= is_leap(yr) ? 366 : 365;
			yr++;
		end
		mon = 0;
		while (mon < 11) begin
			mlen = (mon == 1 && is_leap(yr)) ? 29 : month_days[mon];
			if (days < mlen)
				break;
			days -= mlen;
			mon++;
		end
		c.year  = 12'(yr);
		c.month = 4'(mon + 1);
		c.day   = 5'(days + 1);
		return c;
	endfunction

	function void note_timestamp(logic [31:0] stamp);
		expected_q.push_back(convert(stamp));
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction

	task report(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task check_calendar(calendar_t got);
		calendar_t want;
		checked++;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year,
				got.month, got.day, got.hour, got.minute, got.second));
			return;
		end
		want = expected_q.pop_front();
		if (got.year != want.year)
			report($sformatf("year %0d, want %0d", got.year, want.year));
		if (got.month != want.month)
			report($sformatf("month %0d, want %0d", got.month, want.month));
		if (got.day != want.day)
			report($sformatf("day %0d, want %0d", got.day, want.day));
		if (got.hour != want.hour)
			report($sformatf("hour %0d, want %0d", got.hour, want.hour));
		if (got.minute != want.minute)
			report($sformatf("minute %0d, want %0d", got.minute, want.minute));
		if (got.second != want.second)
			report($sformatf("second %0d, want %0d", got.second, want.second));
	endtask
endclass

module unix_seconds_to_calendar_core_test;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        ts_valid     = 1'b0;
	logic        ts_stall;
	logic [31:0] unix_seconds = '0;
	logic        cal_valid;
	logic        cal_stall    = 1'b0;
	logic [11:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;

	calendar_board board = new;
	int unsigned   tx_idle_pct   = 0;
	int unsigned   rx_idle_pct   = 0;
	bit            long_hold_req = 1'b0;
	int unsigned   hold_left     = 0;
	int unsigned   accepted      = 0;
	calendar_t     got_cal;

	logic [31:0] directed_stamps[] = '{
		32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
		32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000, 32'd94694399,
		32'd951782400, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4107456000, 32'd4107542400,
		32'd4133980799, 32'd4133980800, 32'd4260211200, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
		32'h5555_5555, 32'hAAAA_AAAA
	};

	unix_seconds_to_calendar_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.ts_valid     (ts_valid),
		.ts_stall     (ts_stall),
		.unix_seconds (unix_seconds),
		.cal_valid    (cal_valid),
		.cal_stall    (cal_stall),
		.year_out     (year_out),
		.month_out    (month_out),
		.day_out      (day_out),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.second_out   (second_out)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (cal_valid && !cal_stall) begin
			got_cal = {year_out, month_out, day_out, hour_out, minute_out, second_out};
			board.check_calendar(got_cal);
		end
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			cal_stall <= 1'b1;
		end else begin
			cal_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	function logic [31:0] pick_timestamp();
		longint v;
		case ($urandom_range(3))
			2: begin
				v = longint'($urandom_range(49710)) * 86400 + ($urandom_range(1) ? 0 : 86399);
				if (v > 64'hFFFF_FFFF)
					v = 64'hFFFF_FFFF;
				return v[31:0];
			end
			3: return $urandom_range(1) ? $urandom_range(200000)
				: 32'hFFFF_FFFF - $urandom_range(200000);
			default: return $urandom;
		endcase
	endfunction

	task send_timestamp(input logic [31:0] stamp);
		int unsigned gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			ts_valid <= 1'b0;
			unix_seconds <= $urandom;
			repeat (gap) @(posedge clk);
		end
		ts_valid <= 1'b1;
		unix_seconds <= stamp;
		do @(posedge clk); while (ts_stall);
		board.note_timestamp(stamp);
		accepted++;
	endtask

	task send_random(input int unsigned n);
		repeat (n) send_timestamp(pick_timestamp());
	endtask

	// sender holds off until every outstanding transaction has come back
	task drain();
		ts_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		#20_000_000;
		$display("unix_seconds_to_calendar_core_test NOT OK");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 38;
		rx_idle_pct = 66;
		foreach (directed_stamps[i])
			send_timestamp(directed_stamps[i]);
		send_random(140);
		drain();

		tx_idle_pct = 66;
		rx_idle_pct = 38;
		send_random(150);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		long_hold_req = 1'b1;
		send_random(150);
		drain();
		repeat (200) @(posedge clk);

		$display("%0d timestamps converted, %0d results checked, %0d mismatches",
			accepted, board.checked, board.mismatches);
		$display("covered range edges, leap rules and three pacing phases with a long hold");
		if (board.mismatches == 0 && board.pending() == 0)
			$display("unix_seconds_to_calendar_core_test OK");
		else
			$display("unix_seconds_to_calendar_core_test NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ucal_pkg.sv
rtl/ucal_ctrl.sv
rtl/ucal_dp.sv
rtl/unix_seconds_to_calendar_core.sv
rtl/ucal_checker.sv
tb/unix_seconds_to_calendar_core_test.sv
